>>> hw/rtl/lrc_pkg.sv
// Shared types, codes and the CRC-32 lookup table for the log record checker.
package lrc_pkg;

  localparam int CRC_TABLE_DEPTH = 256;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
  localparam logic [31:0] MAX_LEN_RESET = 32'd67108864;
  localparam logic [7:0] PUT_CODE_RESET = 8'd0;
  localparam logic [31:0] MIN_PAYLOAD = 32'd13;

  // configuration register indexes
  localparam logic CFG_MAX_LEN = 1'b0;
  localparam logic CFG_PUT_CODE = 1'b1;

  // input commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_KEY = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_RECORD = 2'd2;
  localparam logic [1:0] KIND_END = 2'd3;

  // status codes
  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_CLEAN_END = 4'd1;
  localparam logic [3:0] ST_SHORT_HDR = 4'd2;
  localparam logic [3:0] ST_TOO_LONG = 4'd3;
  localparam logic [3:0] ST_SHORT_PAYLOAD = 4'd4;
  localparam logic [3:0] ST_CRC_BAD = 4'd5;
  localparam logic [3:0] ST_UNDER_MIN = 4'd6;
  localparam logic [3:0] ST_KEY_OVERRUN = 4'd7;
  localparam logic [3:0] ST_NO_VLEN = 4'd8;
  localparam logic [3:0] ST_VALUE_OVERRUN = 4'd9;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [7:0]  entry_type;
    logic [63:0] sequence_res;
    logic [31:0] key_length;
    logic [31:0] value_length;
    logic [3:0]  status;
    logic [63:0] next_sequence;
    logic        last;
  } out_item_t;

  typedef logic [31:0] crc_table_t [CRC_TABLE_DEPTH];

  // evaluated at elaboration only
  function automatic crc_table_t crc_table_gen();
    crc_table_t t;
    logic [31:0] c;
    for (int i = 0; i < CRC_TABLE_DEPTH; i++) begin
      c = 32'(i);
      for (int j = 0; j < 8; j++) begin
        c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      t[i] = c;
    end
    return t;
  endfunction

  localparam crc_table_t CRC_TABLE = crc_table_gen();

  function automatic out_item_t mk_result(logic [1:0] kind, logic [7:0] b, logic [7:0] typ,
                                          logic [63:0] seq, logic [31:0] klen,
                                          logic [31:0] vlen, logic [3:0] status,
                                          logic [63:0] hnext);
    out_item_t r;
    r.kind = kind;
    r.out_byte = b;
    r.entry_type = typ;
    r.sequence_res = seq;
    r.key_length = klen;
    r.value_length = vlen;
    r.status = status;
    r.next_sequence = hnext;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

>>> hw/rtl/log_record_checker_core.sv
// Log record checker: framed record parser with CRC-32 check and key/value streaming.
// Results queue at the accepting edge; from an empty queue the first shows next cycle.
// Throughput: one input byte per cycle; each byte yields zero, one or two results,
// drained one per cycle, unless out_stall, from a four-entry queue (input stalls at >2).
// CRC does a byte-wide lookup per cycle a byte is taken; field checks are combinational.
// Reset (synchronous, active low) clears parse state, the queue and the config registers.
module log_record_checker_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  lrc_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lrc_pkg::out_item_t out_data
);
  import lrc_pkg::*;

  localparam int QDEPTH = 4;
  localparam logic PH_HEADER = 1'b0;
  localparam logic PH_PAYLOAD = 1'b1;

  logic [31:0] max_len_r;
  logic [7:0]  put_code_r;

  logic        phase_r, phase_nxt;
  logic [31:0] off_r, off_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] scrc_r, scrc_nxt;
  logic [31:0] rcrc_r, rcrc_nxt;
  logic [7:0]  rtype_r, rtype_nxt;
  logic [63:0] rseq_r, rseq_nxt;
  logic [31:0] klen_r, klen_nxt;
  logic [31:0] vlen_r, vlen_nxt;
  logic [3:0]  fault_r, fault_nxt;
  logic        stopped_r, stopped_nxt;
  logic [63:0] hnext_r, hnext_nxt;

  out_item_t   q_r [QDEPTH];
  out_item_t   q_nxt [QDEPTH];
  logic [2:0]  cnt_r, cnt_nxt, cnt_pop;

  logic        accept, pop;
  logic [1:0]  n_res;
  out_item_t   res0, res1, vres;
  logic        do_verdict, is_put, verd_ok;
  logic [33:0] vb;
  logic [32:0] p_plus1;
  logic [31:0] p;
  logic [7:0]  b;
  logic [3:0]  end_status, fail_status;

  assign in_stall  = cnt_r > 3'd2;
  assign accept    = in_valid && !in_stall;
  assign out_valid = cnt_r != 3'd0;
  assign out_data  = q_r[0];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    phase_nxt = phase_r;
    off_nxt = off_r;
    len_nxt = len_r;
    scrc_nxt = scrc_r;
    rcrc_nxt = rcrc_r;
    rtype_nxt = rtype_r;
    rseq_nxt = rseq_r;
    klen_nxt = klen_r;
    vlen_nxt = vlen_r;
    fault_nxt = fault_r;
    stopped_nxt = stopped_r;
    hnext_nxt = hnext_r;
    n_res = 2'd0;
    res0 = '0;
    res1 = '0;
    vres = '0;
    do_verdict = 1'b0;
    is_put = 1'b0;
    verd_ok = 1'b0;
    vb = '0;
    p = off_r;
    p_plus1 = {1'b0, off_r} + 33'd1;
    b = in_data.data_byte;
    end_status = ST_CLEAN_END;
    fail_status = ST_OK;

    if (accept) begin
      if (in_data.command == CMD_END) begin
        if (stopped_r) begin
          end_status = fault_r;
        end else if (phase_r == PH_PAYLOAD) begin
          end_status = ST_SHORT_PAYLOAD;
        end else if (off_r == 32'd0) begin
          end_status = ST_CLEAN_END;
        end else begin
          end_status = ST_SHORT_HDR;
        end
        res0 = mk_result(KIND_END, 8'd0, 8'd0, 64'd0, 32'd0, 32'd0, end_status, hnext_r);
        n_res = 2'd1;
        phase_nxt = PH_HEADER;
        off_nxt = '0;
        len_nxt = '0;
        scrc_nxt = '0;
        rcrc_nxt = CRC_ONES;
        rtype_nxt = '0;
        rseq_nxt = '0;
        klen_nxt = '0;
        vlen_nxt = '0;
        fault_nxt = ST_OK;
        stopped_nxt = 1'b0;
        hnext_nxt = 64'd1;
      end else if (!stopped_r) begin
        if (phase_r == PH_PAYLOAD) begin
          rcrc_nxt = (rcrc_r >> 8) ^ CRC_TABLE[rcrc_r[7:0] ^ b];
          if (p == 32'd0) begin
            rtype_nxt = b;
          end else if (p <= 32'd8) begin
            rseq_nxt[{p[2:0] - 3'd1, 3'b000} +: 8] = rseq_r[{p[2:0] - 3'd1, 3'b000} +: 8] | b;
          end else if (p <= 32'd12) begin
            klen_nxt[{p[1:0] - 2'd1, 3'b000} +: 8] = klen_r[{p[1:0] - 2'd1, 3'b000} +: 8] | b;
          end
          is_put = rtype_nxt == put_code_r;
          vb = {2'b00, klen_nxt} + 34'd13;

          if (p == 32'd12 && fault_r == ST_OK) begin
            if (vb > {2'b00, len_r}) begin
              fault_nxt = ST_KEY_OVERRUN;
            end else if (is_put && (vb + 34'd4 > {2'b00, len_r})) begin
              fault_nxt = ST_NO_VLEN;
            end
          end
          if (p >= 32'd13 && fault_nxt == ST_OK) begin
            if ({2'b00, p} < vb) begin
              res0 = mk_result(KIND_KEY, b, 8'd0, 64'd0, 32'd0, 32'd0, ST_OK, hnext_r);
              n_res = 2'd1;
            end else if (is_put && ({2'b00, p} < vb + 34'd4)) begin
              // value length lane is the offset past the key
              vlen_nxt[{p[1:0] - vb[1:0], 3'b000} +: 8] =
                vlen_r[{p[1:0] - vb[1:0], 3'b000} +: 8] | b;
              if ({2'b00, p} == vb + 34'd3 &&
                  vb + 34'd4 + {2'b00, vlen_nxt} > {2'b00, len_r}) begin
                fault_nxt = ST_VALUE_OVERRUN;
              end
            end else if (is_put && ({2'b00, p} < vb + 34'd4 + {2'b00, vlen_r})) begin
              res0 = mk_result(KIND_VALUE, b, 8'd0, 64'd0, 32'd0, 32'd0, ST_OK, hnext_r);
              n_res = 2'd1;
            end
          end
          if (p_plus1 >= {1'b0, len_r}) begin
            do_verdict = 1'b1;
          end else begin
            off_nxt = off_r + 32'd1;
          end
        end else begin
          if (off_r < 32'd4) begin
            len_nxt[{off_r[1:0], 3'b000} +: 8] = len_r[{off_r[1:0], 3'b000} +: 8] | b;
          end else begin
            scrc_nxt[{off_r[1:0], 3'b000} +: 8] = scrc_r[{off_r[1:0], 3'b000} +: 8] | b;
          end
          off_nxt = off_r + 32'd1;
          if (p_plus1 >= 33'd8) begin
            if (len_nxt > max_len_r) begin
              stopped_nxt = 1'b1;
              fault_nxt = ST_TOO_LONG;
              res0 = mk_result(KIND_END, 8'd0, 8'd0, 64'd0, 32'd0, 32'd0, ST_TOO_LONG,
                               hnext_r);
              n_res = 2'd1;
            end else begin
              off_nxt = '0;
              rcrc_nxt = CRC_ONES;
              fault_nxt = ST_OK;
              if (len_nxt == 32'd0) begin
                do_verdict = 1'b1;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
        end

        if (do_verdict) begin
          priority if ((rcrc_nxt ^ CRC_ONES) != scrc_nxt) begin
            fail_status = ST_CRC_BAD;
          end else if (len_nxt < MIN_PAYLOAD) begin
            fail_status = ST_UNDER_MIN;
          end else if (fault_nxt != ST_OK) begin
            fail_status = fault_nxt;
          end else begin
            verd_ok = 1'b1;
          end
          if (verd_ok) begin
            if (rseq_nxt >= hnext_r) begin
              hnext_nxt = (rseq_nxt == '1) ? rseq_nxt : rseq_nxt + 64'd1;
            end
            vres = mk_result(KIND_RECORD, 8'd0, rtype_nxt, rseq_nxt, klen_nxt,
                             (rtype_nxt == put_code_r) ? vlen_nxt : 32'd0, ST_OK,
                             hnext_nxt);
            phase_nxt = PH_HEADER;
            off_nxt = '0;
            len_nxt = '0;
            scrc_nxt = '0;
            rcrc_nxt = CRC_ONES;
            rtype_nxt = '0;
            rseq_nxt = '0;
            klen_nxt = '0;
            vlen_nxt = '0;
            fault_nxt = ST_OK;
          end else begin
            stopped_nxt = 1'b1;
            fault_nxt = fail_status;
            vres = mk_result(KIND_END, 8'd0, 8'd0, 64'd0, 32'd0, 32'd0, fail_status,
                             hnext_r);
          end
          if (n_res == 2'd0) begin
            res0 = vres;
          end else begin
            res1 = vres;
          end
          n_res = n_res + 2'd1;
        end
      end
      // mark the final result of this transaction
      if (n_res == 2'd1) begin
        res0.last = 1'b1;
      end else if (n_res == 2'd2) begin
        res1.last = 1'b1;
      end
    end
  end

  // output queue: entry 0 is the head; shifts down on pop
  always_comb begin
    cnt_pop = cnt_r - {2'b00, pop};
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
      if (pop && i < QDEPTH - 1) begin
        q_nxt[i] = q_r[(i < QDEPTH - 1) ? i + 1 : i];
      end
      if (n_res != 2'd0 && 3'(i) == cnt_pop) begin
        q_nxt[i] = res0;
      end
      if (n_res == 2'd2 && 3'(i) == cnt_pop + 3'd1) begin
        q_nxt[i] = res1;
      end
    end
    cnt_nxt = cnt_pop + {1'b0, n_res};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
      put_code_r <= PUT_CODE_RESET;
      phase_r <= PH_HEADER;
      off_r <= '0;
      len_r <= '0;
      scrc_r <= '0;
      rcrc_r <= CRC_ONES;
      rtype_r <= '0;
      rseq_r <= '0;
      klen_r <= '0;
      vlen_r <= '0;
      fault_r <= ST_OK;
      stopped_r <= 1'b0;
      hnext_r <= 64'd1;
      cnt_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_MAX_LEN:  max_len_r <= cfg_wdata;
          CFG_PUT_CODE: put_code_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      phase_r <= phase_nxt;
      off_r <= off_nxt;
      len_r <= len_nxt;
      scrc_r <= scrc_nxt;
      rcrc_r <= rcrc_nxt;
      rtype_r <= rtype_nxt;
      rseq_r <= rseq_nxt;
      klen_r <= klen_nxt;
      vlen_r <= vlen_nxt;
      fault_r <= fault_nxt;
      stopped_r <= stopped_nxt;
      hnext_r <= hnext_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
